// ===== hdl/asf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the color preset table of the strobe flasher.
// Used by the interfaces and by every module of the block.
package asf_pkg;

    localparam int TimeWidth   = 32;
    localparam int ColWidth    = 8;
    localparam int PeriodWidth = 10;
    localparam int HalfWidth   = 9;
    localparam int NumChan     = 6;
    localparam int ModStep     = 8;
    localparam int ModStages   = TimeWidth / ModStep;

    localparam int PeriodMax  = 800;
    localparam int PeriodMin  = 120;
    localparam int DropMul    = 680;
    localparam int DropDiv    = 99;
    localparam int ColDiv     = 255;
    localparam int MarkOn1    = 60;
    localparam int MarkOff1   = 100;
    localparam int MarkOn2    = 160;

    // Division by a constant is done as a multiplication by a rounded-up reciprocal.
    // The scale is wide enough that the result is exact over the whole input range.
    localparam int DropShift     = 24;
    localparam int DropRecip     = ((1 << DropShift) + DropDiv - 1) / DropDiv;
    localparam int DropMulRecip  = DropMul * DropRecip;
    localparam int ColShift      = 24;
    localparam int ColRecip      = ((1 << ColShift) + ColDiv - 1) / ColDiv;

    // The compressed flash marks are 3/8 and 5/8 of the half period.
    localparam int MarkShift   = 3;
    localparam int MarkOn1Num  = MarkOn1 * (1 << MarkShift) / MarkOn2;
    localparam int MarkOff1Num = MarkOff1 * (1 << MarkShift) / MarkOn2;

    localparam logic [1:0] REG_PRESET = 2'd0;
    localparam logic [1:0] REG_SPEED  = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;

    localparam logic [1:0] RstPreset = 2'd2;
    localparam logic [6:0] RstSpeed  = 7'd50;
    localparam logic [7:0] RstBright = 8'd255;

    localparam logic [1:0] SettleCycles = 2'd3;

    typedef logic [ColWidth-1:0] t_col;

    typedef struct packed {
        logic [PeriodWidth-1:0]        period;
        logic [HalfWidth-1:0]          half;
        logic [HalfWidth-1:0]          on1;
        logic [HalfWidth-1:0]          off1;
        logic [HalfWidth-1:0]          on2;
        logic [NumChan-1:0][ColWidth-1:0] col;
    } t_cfg;

    localparam t_col PRESET_TAB [4][NumChan] = '{
        '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd140, 8'd0,   8'd255, 8'd140, 8'd0}
    };

endpackage

// ===== hdl/asf_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the strobe flasher: input word, result word, register writes.
// Depends on asf_pkg for field widths.
interface asf_in_if;
    logic                              valid;
    logic                              ready;
    logic [asf_pkg::TimeWidth-1:0]     time_ms;
    modport source (output valid, output time_ms, input ready);
    modport sink (input valid, input time_ms, output ready);
endinterface

interface asf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  left_red;
    logic [7:0]  left_green;
    logic [7:0]  left_blue;
    logic [7:0]  right_red;
    logic [7:0]  right_green;
    logic [7:0]  right_blue;
    modport source (output valid, output left_red, output left_green, output left_blue,
                    output right_red, output right_green, output right_blue, input ready);
    modport sink (input valid, input left_red, input left_green, input left_blue,
                  input right_red, input right_green, input right_blue, output ready);
endinterface

interface asf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [7:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/asf_cfg.sv =====
`timescale 1ns / 1ps
// Register file, the derived timing marks, three register layers deep, and the scaled colors.
// Depends on asf_pkg and asf_cfg_if.
module asf_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    asf_cfg_if.sink           i_cfg,
    output asf_pkg::t_cfg     o_cfg,
    output logic              o_busy
);

    logic [1:0]  r_preset;
    logic [6:0]  r_speed;
    logic [7:0]  r_bright;
    logic [1:0]  r_settle;

    logic [33:0] r_prod;
    logic [15:0] r_mix [asf_pkg::NumChan];
    logic [asf_pkg::PeriodWidth-1:0] r_period;
    logic [asf_pkg::NumChan-1:0][asf_pkg::ColWidth-1:0] r_col;
    logic [asf_pkg::HalfWidth-1:0] r_half, r_on1, r_off1, r_on2;

    logic [6:0]  n_speed;
    logic [9:0]  n_drop;
    logic [asf_pkg::HalfWidth-1:0] n_half;
    logic [32:0] n_colp [asf_pkg::NumChan];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= asf_pkg::RstPreset;
            r_speed  <= asf_pkg::RstSpeed;
            r_bright <= asf_pkg::RstBright;
            r_settle <= asf_pkg::SettleCycles;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_settle <= asf_pkg::SettleCycles;
                case (i_cfg.index)
                    asf_pkg::REG_PRESET: r_preset <= i_cfg.data[1:0];
                    asf_pkg::REG_SPEED:  r_speed  <= i_cfg.data[6:0];
                    asf_pkg::REG_BRIGHT: r_bright <= i_cfg.data;
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_comb begin
        n_speed = (r_speed == 7'd0) ? 7'd1 : r_speed;
        n_drop  = r_prod[asf_pkg::DropShift+asf_pkg::PeriodWidth-1:asf_pkg::DropShift];
        n_half  = r_period[asf_pkg::PeriodWidth-1:1];
        for (int c = 0; c < asf_pkg::NumChan; c++) begin
            n_colp[c] = 33'(r_mix[c]) * 33'(asf_pkg::ColRecip);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 34'(n_speed - 7'd1) * 34'(asf_pkg::DropMulRecip);
        for (int c = 0; c < asf_pkg::NumChan; c++) begin
            r_mix[c] <= 16'(asf_pkg::PRESET_TAB[r_preset][c]) * 16'(r_bright);
            r_col[c] <= n_colp[c][asf_pkg::ColShift+asf_pkg::ColWidth-1:asf_pkg::ColShift];
        end
        r_period <= (n_drop >= 10'(asf_pkg::DropMul)) ? 10'(asf_pkg::PeriodMin)
                                                     : 10'(asf_pkg::PeriodMax) - n_drop;
        r_half <= n_half;
        if (n_half < 9'(asf_pkg::MarkOn2)) begin
            r_on1  <= 9'((12'(n_half) * 12'(asf_pkg::MarkOn1Num)) >> asf_pkg::MarkShift);
            r_off1 <= 9'((12'(n_half) * 12'(asf_pkg::MarkOff1Num)) >> asf_pkg::MarkShift);
            r_on2  <= n_half;
        end else begin
            r_on1  <= 9'(asf_pkg::MarkOn1);
            r_off1 <= 9'(asf_pkg::MarkOff1);
            r_on2  <= 9'(asf_pkg::MarkOn2);
        end
    end

    assign o_cfg.period = r_period;
    assign o_cfg.half   = r_half;
    assign o_cfg.on1    = r_on1;
    assign o_cfg.off1   = r_off1;
    assign o_cfg.on2    = r_on2;
    assign o_cfg.col    = r_col;
    assign o_busy       = (r_settle != 2'd0);

endmodule

// ===== hdl/asf_mod_stage.sv =====
`timescale 1ns / 1ps
// One stage of the pipelined time-modulo-period unit, eight restoring steps per stage.
// Depends on asf_pkg.
module asf_mod_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [asf_pkg::PeriodWidth-1:0]      i_period,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [asf_pkg::PeriodWidth-1:0]      i_rem,
    input  logic [asf_pkg::TimeWidth-1:0]        i_bits,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [asf_pkg::PeriodWidth-1:0]      o_rem,
    output logic [asf_pkg::TimeWidth-1:0]        o_bits
);

    logic                                r_valid;
    logic [asf_pkg::PeriodWidth-1:0]     r_rem;
    logic [asf_pkg::TimeWidth-1:0]       r_bits;
    logic [asf_pkg::PeriodWidth-1:0]     n_rem;
    logic [asf_pkg::PeriodWidth:0]       w_trial;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_rem   = i_rem;
        w_trial = '0;
        for (int k = 0; k < asf_pkg::ModStep; k++) begin
            w_trial = {n_rem, i_bits[asf_pkg::TimeWidth-1-k]};
            if (w_trial >= {1'b0, i_period}) begin
                w_trial = w_trial - {1'b0, i_period};
            end
            n_rem = w_trial[asf_pkg::PeriodWidth-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_bits <= {i_bits[asf_pkg::TimeWidth-asf_pkg::ModStep-1:0],
                       {asf_pkg::ModStep{1'b0}}};
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_bits  = r_bits;

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem < i_period))
        else $error("Partial remainder reached the period.");

endmodule

// ===== hdl/asf_out.sv =====
`timescale 1ns / 1ps
// Final stage: picks the strobing side, checks the flash window and registers the colors.
// Depends on asf_pkg and asf_out_if.
module asf_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  asf_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [asf_pkg::PeriodWidth-1:0]  i_rem,
    asf_out_if.source                        o_res
);

    logic                                               r_valid;
    logic [asf_pkg::NumChan-1:0][asf_pkg::ColWidth-1:0] r_col;
    logic [asf_pkg::NumChan-1:0][asf_pkg::ColWidth-1:0] n_col;
    logic                                               w_left;
    logic                                               w_lit;
    logic [asf_pkg::PeriodWidth-1:0]                    w_t;

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        w_left = i_rem < {1'b0, i_cfg.half};
        w_t    = w_left ? i_rem : i_rem - {1'b0, i_cfg.half};
        w_lit  = (w_t < {1'b0, i_cfg.on1}) ||
                 ((w_t >= {1'b0, i_cfg.off1}) && (w_t < {1'b0, i_cfg.on2}));
        for (int c = 0; c < asf_pkg::NumChan; c++) begin
            n_col[c] = (w_lit && (w_left == (c < 3))) ? i_cfg.col[c] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_col <= n_col;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.left_red    = r_col[0];
    assign o_res.left_green  = r_col[1];
    assign o_res.left_blue   = r_col[2];
    assign o_res.right_red   = r_col[3];
    assign o_res.right_green = r_col[4];
    assign o_res.right_blue  = r_col[5];

    a_one_side_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !((r_col[0] != 8'd0 || r_col[1] != 8'd0 || r_col[2] != 8'd0) &&
                      (r_col[3] != 8'd0 || r_col[4] != 8'd0 || r_col[5] != 8'd0)))
        else $error("Both sides lit in the same word.");

endmodule

// ===== hdl/alternating_strobe_flasher_unit.sv =====
`timescale 1ns / 1ps
// Alternating two-flash strobe: time stamp in, left and right RGB drive out.
// The datapath is four modulo stages followed by one output stage. Throughput is one
// word per cycle, set by the fully pipelined modulo unit, as long as the output is
// not stalled. After reset and after every register write the input is held off while
// the derived period, flash marks and scaled colors settle.
// Depends on asf_pkg, the channel interfaces, asf_cfg, asf_mod_stage and asf_out.
module alternating_strobe_flasher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asf_in_if.sink     i_in,
    asf_cfg_if.sink    i_cfg,
    asf_out_if.source  o_res
);

    asf_pkg::t_cfg w_cfg;
    logic          w_busy;

    logic [asf_pkg::ModStages:0]                         w_valid;
    logic [asf_pkg::ModStages:0]                         w_ready;
    logic [asf_pkg::ModStages:0][asf_pkg::PeriodWidth-1:0] w_rem;
    logic [asf_pkg::ModStages:0][asf_pkg::TimeWidth-1:0]   w_bits;

    asf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg),
        .o_busy  (w_busy)
    );

    assign w_valid[0] = i_in.valid && !w_busy;
    assign w_rem[0]   = '0;
    assign w_bits[0]  = i_in.time_ms;
    assign i_in.ready = w_ready[0] && !w_busy;

    for (genvar s = 0; s < asf_pkg::ModStages; s++) begin : g_mod
        asf_mod_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_period (w_cfg.period),
            .i_valid  (w_valid[s]),
            .o_ready  (w_ready[s]),
            .i_rem    (w_rem[s]),
            .i_bits   (w_bits[s]),
            .o_valid  (w_valid[s+1]),
            .i_ready  (w_ready[s+1]),
            .o_rem    (w_rem[s+1]),
            .o_bits   (w_bits[s+1])
        );
    end

    asf_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_valid[asf_pkg::ModStages]),
        .o_ready (w_ready[asf_pkg::ModStages]),
        .i_rem   (w_rem[asf_pkg::ModStages]),
        .o_res   (o_res)
    );

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !i_in.ready)
        else $error("Input accepted before register-derived values settled.");

endmodule
